/* rtl/ble_pkg.sv */
`timescale 1ns / 1ps
package ble_pkg;

	localparam int MEM_BYTES = 1024;
	localparam int BANKS     = 4;
	localparam int ROWS      = MEM_BYTES / BANKS;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int LOC_W     = $clog2(MEM_BYTES);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	localparam logic [5:0] OP_LB  = 6'd32;
	localparam logic [5:0] OP_LH  = 6'd33;
	localparam logic [5:0] OP_LW  = 6'd35;
	localparam logic [5:0] OP_LBU = 6'd36;
	localparam logic [5:0] OP_LHU = 6'd37;
	localparam logic [5:0] OP_SB  = 6'd40;
	localparam logic [5:0] OP_SH  = 6'd41;
	localparam logic [5:0] OP_SW  = 6'd43;

	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] address;
		logic [31:0] store_data;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        unknown_opcode;
	} rsp_t;

	typedef struct packed {
		logic [BANKS-1:0]            we;
		logic [BANKS-1:0][ROW_W-1:0] row;
		logic [BANKS-1:0][7:0]       wdata;
	} bank_req_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	function automatic logic is_load(input logic [5:0] kind);
		return kind inside {OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU};
	endfunction

	function automatic logic is_store(input logic [5:0] kind);
		return kind inside {OP_SW, OP_SH, OP_SB};
	endfunction

endpackage

/* rtl/ble_ram.sv */
`timescale 1ns / 1ps
module ble_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/ble_addr_map.sv */
`timescale 1ns / 1ps
module ble_addr_map
	import ble_pkg::*;
(
	input  req_t      req,
	output bank_req_t bank
);

	logic [LOC_W-1:0] loc;
	logic [1:0]       off;
	logic [ROW_W-1:0] row;
	logic [1:0]       last;

	assign loc = req.address[LOC_W-1:0];
	assign off = loc[1:0];
	assign row = loc[LOC_W-1:2];

	always_comb begin
		case (req.kind)
			OP_SW:   last = 2'd3;
			OP_SH:   last = 2'd1;
			default: last = 2'd0;
		endcase
	end

	always_comb begin
		logic [1:0] bi;
		logic [1:0] k;
		logic [1:0] j;
		for (int b = 0; b < BANKS; b++) begin
			bi = 2'(b);
			k  = bi - off;
			j  = last - k;
			bank.we[b]    = is_store(req.kind) && (k <= last);
			bank.row[b]   = row + ROW_W'(bi < off);
			bank.wdata[b] = req.store_data[{j, 3'b000} +: 8];
		end
	end

endmodule

/* rtl/ble_load_align.sv */
`timescale 1ns / 1ps
module ble_load_align
	import ble_pkg::*;
(
	input  req_t                  req,
	input  logic [BANKS-1:0][7:0] rdata,
	output rsp_t                  rsp
);

	logic [1:0]       off;
	logic [3:0][7:0]  bytes;

	assign off = req.address[1:0];

	always_comb begin
		for (int k = 0; k < BANKS; k++) begin
			bytes[k] = rdata[off + 2'(k)];
		end
	end

	always_comb begin
		rsp.unknown_opcode = 1'b0;
		case (req.kind)
			OP_LW:   rsp.result = {bytes[0], bytes[1], bytes[2], bytes[3]};
			OP_LH:   rsp.result = {{16{bytes[0][7]}}, bytes[0], bytes[1]};
			OP_LHU:  rsp.result = {16'h0000, bytes[0], bytes[1]};
			OP_LB:   rsp.result = {{24{bytes[0][7]}}, bytes[0]};
			OP_LBU:  rsp.result = {24'h000000, bytes[0]};
			default: begin
				rsp.result         = req.address;
				rsp.unknown_opcode = !is_store(req.kind);
			end
		endcase
	end

endmodule

/* rtl/big_endian_load_store_unit.sv */
`timescale 1ns / 1ps
// An accepted request passes the bank read register, then the output register, before its response is valid.
// Throughput: one transaction per cycle unless stalled; four byte banks serve any aligned or unaligned access.
// Reset: asynchronous, active low. Afterwards a clearing pass zeroes one row of all banks
// per cycle until all MEM_BYTES/4 rows (256 at 1024 bytes) are zeroed; no request is accepted meanwhile.
module big_endian_load_store_unit
	import ble_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t           state_q, state_d;
	logic [ROW_W-1:0] clr_row_q;
	logic             clearing;

	logic             valid_s1;
	req_t             req_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             move;
	logic             ready;
	logic             accept;
	bank_req_t        bank;
	logic [BANKS-1:0][7:0] rdata;
	rsp_t             rsp_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_row_q == ROW_LAST) state_d = ST_RUN;
			ST_RUN:   state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			default:  clearing = 1'b0;
		endcase
	end

	assign move   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign ready  = !clearing && (!valid_s1 || move);
	assign accept = req_valid && ready;

	assign req_stall = !ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ble_addr_map u_map (
		.req  (req),
		.bank (bank)
	);

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic             we;
		logic [ROW_W-1:0] addr;
		logic [7:0]       wdata;

		assign we    = clearing || (accept && bank.we[b]);
		assign addr  = clearing ? clr_row_q : bank.row[b];
		assign wdata = clearing ? 8'h00 : bank.wdata[b];

		ble_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.re    (accept && is_load(req.kind)),
			.addr  (addr),
			.wdata (wdata),
			.rdata (rdata[b])
		);
	end

	ble_load_align u_align (
		.req   (req_s1),
		.rdata (rdata),
		.rsp   (rsp_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_row_q <= clr_row_q + 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (move) begin
			rsp_q <= rsp_s1;
		end
	end

endmodule
